/* hw/rtl/cmmu_pkg.sv */
`timescale 1ns / 1ps
package cmmu_pkg;

  localparam int SIDE   = 64;
  localparam int STATES = 6;

  localparam int XW     = $clog2(SIDE);
  localparam int DEPTH  = SIDE * SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int SPIN_W = 3;
  localparam int BETA_W = 16;
  localparam int RND_W  = 16;

  localparam logic [BETA_W-1:0] BETA_RESET = 16'd4096;

  // coordinate reduction steps for a 6-bit input coordinate
  localparam int COORD_ITER = (SIDE >= 64) ? 0 : (63 / SIDE);

  localparam int COS_W  = 16;
  localparam int DSUM_W = COS_W + 3;
  localparam int CHG_W  = DSUM_W + BETA_W + 1;

  // change in Q.26 -> Q.16
  localparam int X_LO   = 10;
  localparam int XQ_W   = CHG_W - 1 - X_LO;
  localparam int FRAC_W = 16;
  localparam int N_W    = 4;
  localparam logic [XQ_W-1:0] EXP_LIMIT = XQ_W'(12 << 16);

  localparam int TERM_W    = 33;
  localparam int ACC_W     = TERM_W + 3;
  localparam int DIV_STEP  = 8;
  localparam int DIV_W     = ((TERM_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int DIV_CYC   = DIV_W / DIV_STEP;
  localparam int DCNT_W    = $clog2(DIV_CYC + 1);
  localparam int K_W       = 4;
  localparam int SER_TERMS = 14;

  localparam logic [TERM_W-1:0] ONE_Q32 = TERM_W'(64'h1_0000_0000);
  localparam logic [31:0]       E1_Q32  = 32'd1580030169;
  localparam logic [TERM_W-1:0] HALF_Q16 = TERM_W'(32768);

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;

  localparam logic signed [COS_W-1:0] COS_ROWS [0:8][0:7] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, -16'sd8192, -16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd16384, 16'sd5063, -16'sd13255, -16'sd13255, 16'sd5063, 16'sd0, 16'sd0,
      16'sd0},
    '{16'sd16384, 16'sd8192, -16'sd8192, -16'sd16384, -16'sd8192, 16'sd8192, 16'sd0,
      16'sd0},
    '{16'sd16384, 16'sd10215, -16'sd3646, -16'sd14761, -16'sd14761, -16'sd3646,
      16'sd10215, 16'sd0},
    '{16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384, -16'sd11585, 16'sd0,
      16'sd11585}
  };

  typedef struct packed {
    logic [1:0]        op;
    logic [5:0]        site_x;
    logic [5:0]        site_y;
    logic [SPIN_W-1:0] proposed_spin;
    logic [RND_W-1:0]  random_fraction;
  } in_t;

  typedef struct packed {
    logic              accepted;
    logic [SPIN_W-1:0] site_spin;
  } out_t;

  typedef enum logic [2:0] {
    A_SITE,
    A_XP,
    A_YP,
    A_XM,
    A_YM
  } addr_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_SITE,
    S_RD_XP,
    S_RD_YP,
    S_RD_XM,
    S_RD_YM,
    S_NB_LAST,
    S_SCALE,
    S_CHECK,
    S_SER_MUL,
    S_SER_DIV,
    S_SER_ACC,
    S_CLAMP,
    S_POW,
    S_DECIDE,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic      load_item;
    addr_sel_t addr_sel;
    logic      cap_old;
    logic      nb_acc;
    logic      scale;
    logic      ser_init;
    logic      ser_mul;
    logic      ser_div;
    logic      ser_acc;
    logic      clamp;
    logic      pow_step;
    logic      mem_write;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       change_le0;
    logic       change_big;
    logic       div_last;
    logic       ser_last;
    logic       pow_zero;
    logic       mc_pass;
    logic       out_free;
  } status_t;

  function automatic logic [SPIN_W-1:0] spin_mod(input logic [SPIN_W-1:0] s);
    logic [SPIN_W:0] v;
    v = {1'b0, s};
    for (int i = 0; i < 3; i++) begin
      if (v >= (SPIN_W+1)'(STATES)) begin
        v = v - (SPIN_W+1)'(STATES);
      end
    end
    return v[SPIN_W-1:0];
  endfunction

  function automatic logic signed [COS_W-1:0] cos_of(input logic [SPIN_W-1:0] a,
                                                     input logic [SPIN_W-1:0] b);
    logic [SPIN_W:0] d;
    d = {1'b0, spin_mod(a)} + (SPIN_W+1)'(STATES) - {1'b0, spin_mod(b)};
    if (d >= (SPIN_W+1)'(STATES)) begin
      d = d - (SPIN_W+1)'(STATES);
    end
    return COS_ROWS[STATES][d[2:0]];
  endfunction

  function automatic logic [XW-1:0] coord_mod(input logic [5:0] c);
    logic [8:0] w;
    w = {3'b000, c};
    for (int i = 0; i < COORD_ITER; i++) begin
      if (w >= 9'(SIDE)) begin
        w = w - 9'(SIDE);
      end
    end
    return XW'(w);
  endfunction

  function automatic logic [AW-1:0] site_addr(input logic [XW-1:0] x,
                                              input logic [XW-1:0] y);
    return AW'(int'(x) * SIDE + int'(y));
  endfunction

endpackage

/* hw/rtl/cmmu_ram.sv */
`timescale 1ns / 1ps
module cmmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/cmmu_ctrl.sv */
`timescale 1ns / 1ps
module cmmu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cmmu_pkg::status_t status,
  output cmmu_pkg::cmd_t    cmd
);

  cmmu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cmmu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.addr_sel = cmmu_pkg::A_SITE;
    in_ready     = 1'b0;
    case (state_r)
      cmmu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = cmmu_pkg::S_RD_SITE;
        end
      end
      cmmu_pkg::S_RD_SITE: begin
        cmd.addr_sel = cmmu_pkg::A_SITE;
        state_nxt = (status.op == cmmu_pkg::OP_LOAD) ? cmmu_pkg::S_WRITE
                                                     : cmmu_pkg::S_RD_XP;
      end
      cmmu_pkg::S_RD_XP: begin
        cmd.addr_sel = cmmu_pkg::A_XP;
        cmd.cap_old  = 1'b1;
        state_nxt = (status.op == cmmu_pkg::OP_UPDATE) ? cmmu_pkg::S_RD_YP
                                                       : cmmu_pkg::S_DONE;
      end
      cmmu_pkg::S_RD_YP: begin
        cmd.addr_sel = cmmu_pkg::A_YP;
        cmd.nb_acc   = 1'b1;
        state_nxt    = cmmu_pkg::S_RD_XM;
      end
      cmmu_pkg::S_RD_XM: begin
        cmd.addr_sel = cmmu_pkg::A_XM;
        cmd.nb_acc   = 1'b1;
        state_nxt    = cmmu_pkg::S_RD_YM;
      end
      cmmu_pkg::S_RD_YM: begin
        cmd.addr_sel = cmmu_pkg::A_YM;
        cmd.nb_acc   = 1'b1;
        state_nxt    = cmmu_pkg::S_NB_LAST;
      end
      cmmu_pkg::S_NB_LAST: begin
        cmd.nb_acc = 1'b1;
        state_nxt  = cmmu_pkg::S_SCALE;
      end
      cmmu_pkg::S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = cmmu_pkg::S_CHECK;
      end
      cmmu_pkg::S_CHECK: begin
        if (status.change_le0) begin
          state_nxt = cmmu_pkg::S_WRITE;
        end else if (status.change_big) begin
          state_nxt = cmmu_pkg::S_DONE;
        end else begin
          cmd.ser_init = 1'b1;
          state_nxt    = cmmu_pkg::S_SER_MUL;
        end
      end
      cmmu_pkg::S_SER_MUL: begin
        cmd.ser_mul = 1'b1;
        state_nxt   = cmmu_pkg::S_SER_DIV;
      end
      cmmu_pkg::S_SER_DIV: begin
        cmd.ser_div = 1'b1;
        if (status.div_last) begin
          state_nxt = cmmu_pkg::S_SER_ACC;
        end
      end
      cmmu_pkg::S_SER_ACC: begin
        cmd.ser_acc = 1'b1;
        state_nxt = status.ser_last ? cmmu_pkg::S_CLAMP : cmmu_pkg::S_SER_MUL;
      end
      cmmu_pkg::S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = cmmu_pkg::S_POW;
      end
      cmmu_pkg::S_POW: begin
        if (status.pow_zero) begin
          state_nxt = cmmu_pkg::S_DECIDE;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      cmmu_pkg::S_DECIDE: begin
        state_nxt = status.mc_pass ? cmmu_pkg::S_WRITE : cmmu_pkg::S_DONE;
      end
      cmmu_pkg::S_WRITE: begin
        cmd.mem_write = 1'b1;
        state_nxt     = cmmu_pkg::S_DONE;
      end
      cmmu_pkg::S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = cmmu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cmmu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/cmmu_dp.sv */
`timescale 1ns / 1ps
module cmmu_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmmu_pkg::in_t                 in_data,
  input  cmmu_pkg::cmd_t                cmd,
  output cmmu_pkg::status_t             status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cmmu_pkg::out_t                out_data,
  input  logic                          cfg_wr_en,
  input  logic [cmmu_pkg::BETA_W-1:0]   cfg_wr_data
);

  localparam int XW     = cmmu_pkg::XW;
  localparam int AW     = cmmu_pkg::AW;
  localparam int SW     = cmmu_pkg::SPIN_W;
  localparam int TW     = cmmu_pkg::TERM_W;
  localparam int AC_W   = cmmu_pkg::ACC_W;
  localparam int DW     = cmmu_pkg::DIV_W;
  localparam int CW     = cmmu_pkg::CHG_W;
  localparam int DSW    = cmmu_pkg::DSUM_W;
  localparam int X_LO   = cmmu_pkg::X_LO;
  localparam int FW     = cmmu_pkg::FRAC_W;
  localparam int NW     = cmmu_pkg::N_W;
  localparam int KW     = cmmu_pkg::K_W;

  logic [1:0]                  op_r;
  logic [XW-1:0]               x_r, y_r;
  logic [SW-1:0]               prop_r, old_r;
  logic [cmmu_pkg::RND_W-1:0]  rnd_r;
  logic [cmmu_pkg::BETA_W-1:0] beta_r;
  logic signed [DSW-1:0]       dsum_r;
  logic signed [CW-1:0]        change_r;
  logic signed [AC_W-1:0]      acc_r;
  logic [DW-1:0]               div_r;
  logic [KW-1:0]               rem_r;
  logic [KW-1:0]               k_r;
  logic [cmmu_pkg::DCNT_W-1:0] dcnt_r;
  logic [NW-1:0]               pow_n_r;
  logic [TW-1:0]               r_r;
  logic                        accepted_r;
  logic                        out_valid_r;
  cmmu_pkg::out_t              out_data_r;

  logic [XW-1:0]          xp, xm, yp, ym, rx, ry;
  logic [AW-1:0]          raddr, waddr;
  logic [SW-1:0]          rdata;
  logic signed [DSW-1:0]  nb_diff;
  logic [TW+FW-1:0]       ser_prod;
  logic [TW+31:0]         pow_prod;
  logic [DW-1:0]          div_q;
  logic [KW-1:0]          div_rem;
  logic [KW:0]            div_part;
  logic signed [AC_W-1:0] term_ext;
  logic [TW-1:0]          exp_rnd;

  assign xp = (x_r == XW'(cmmu_pkg::SIDE - 1)) ? '0 : x_r + XW'(1);
  assign xm = (x_r == '0) ? XW'(cmmu_pkg::SIDE - 1) : x_r - XW'(1);
  assign yp = (y_r == XW'(cmmu_pkg::SIDE - 1)) ? '0 : y_r + XW'(1);
  assign ym = (y_r == '0) ? XW'(cmmu_pkg::SIDE - 1) : y_r - XW'(1);

  always_comb begin
    rx = x_r;
    ry = y_r;
    case (cmd.addr_sel)
      cmmu_pkg::A_SITE: begin
        rx = x_r;
        ry = y_r;
      end
      cmmu_pkg::A_XP: rx = xp;
      cmmu_pkg::A_YP: ry = yp;
      cmmu_pkg::A_XM: rx = xm;
      cmmu_pkg::A_YM: ry = ym;
      default: begin
        rx = x_r;
        ry = y_r;
      end
    endcase
  end

  assign raddr = cmmu_pkg::site_addr(rx, ry);
  assign waddr = cmmu_pkg::site_addr(x_r, y_r);

  cmmu_ram #(
    .WIDTH(SW),
    .DEPTH(cmmu_pkg::DEPTH)
  ) u_lattice (
    .clk  (clk),
    .we   (cmd.mem_write),
    .waddr(waddr),
    .wdata(prop_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign nb_diff = DSW'(cmmu_pkg::cos_of(old_r, rdata))
                 - DSW'(cmmu_pkg::cos_of(prop_r, rdata));

  assign ser_prod = div_r[TW-1:0] * change_r[X_LO+FW-1:X_LO];
  assign pow_prod = r_r * cmmu_pkg::E1_Q32;
  assign term_ext = $signed(AC_W'(div_r[TW-1:0]));
  assign exp_rnd  = r_r + cmmu_pkg::HALF_Q16;

  // restoring division by the term index, one chunk of quotient bits a cycle
  always_comb begin
    div_q    = div_r;
    div_rem  = rem_r;
    div_part = '0;
    for (int i = 0; i < cmmu_pkg::DIV_STEP; i++) begin
      div_part = {div_rem, div_q[DW-1]};
      div_q    = {div_q[DW-2:0], 1'b0};
      if (div_part >= {1'b0, k_r}) begin
        div_part = div_part - {1'b0, k_r};
        div_q[0] = 1'b1;
      end
      div_rem = div_part[KW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r      <= cmmu_pkg::BETA_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        beta_r <= cfg_wr_data;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r       <= in_data.op;
      x_r        <= cmmu_pkg::coord_mod(in_data.site_x);
      y_r        <= cmmu_pkg::coord_mod(in_data.site_y);
      prop_r     <= in_data.proposed_spin;
      rnd_r      <= in_data.random_fraction;
      dsum_r     <= '0;
      accepted_r <= 1'b0;
    end
    if (cmd.cap_old) begin
      old_r <= rdata;
    end
    if (cmd.nb_acc) begin
      dsum_r <= dsum_r + nb_diff;
    end
    if (cmd.scale) begin
      change_r <= CW'(dsum_r) * $signed({1'b0, beta_r});
    end
    if (cmd.ser_init) begin
      acc_r   <= $signed(AC_W'(cmmu_pkg::ONE_Q32));
      div_r   <= DW'(cmmu_pkg::ONE_Q32);
      k_r     <= KW'(1);
      pow_n_r <= change_r[X_LO+FW+NW-1:X_LO+FW];
    end
    if (cmd.ser_mul) begin
      div_r  <= DW'(ser_prod[TW+FW-1:FW]);
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.ser_div) begin
      div_r  <= div_q;
      rem_r  <= div_rem;
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.ser_acc) begin
      acc_r <= k_r[0] ? acc_r - term_ext : acc_r + term_ext;
      k_r   <= k_r + KW'(1);
    end
    if (cmd.clamp) begin
      if (acc_r[AC_W-1]) begin
        r_r <= '0;
      end else if (acc_r > $signed(AC_W'(cmmu_pkg::ONE_Q32))) begin
        r_r <= cmmu_pkg::ONE_Q32;
      end else begin
        r_r <= acc_r[TW-1:0];
      end
    end
    if (cmd.pow_step) begin
      r_r     <= pow_prod[TW+31:32];
      pow_n_r <= pow_n_r - NW'(1);
    end
    if (cmd.mem_write) begin
      accepted_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r.accepted  <= accepted_r;
      out_data_r.site_spin <= accepted_r ? prop_r : old_r;
    end
  end

  assign status.op         = op_r;
  assign status.change_le0 = change_r[CW-1] || (change_r == '0);
  assign status.change_big = change_r[CW-2:X_LO] >= cmmu_pkg::EXP_LIMIT;
  assign status.div_last   = dcnt_r == cmmu_pkg::DCNT_W'(cmmu_pkg::DIV_CYC - 1);
  assign status.ser_last   = k_r == KW'(cmmu_pkg::SER_TERMS);
  assign status.pow_zero   = pow_n_r == '0;
  assign status.mc_pass    = exp_rnd[TW-1:16] > {1'b0, rnd_r};
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/clock_model_metropolis_update.sv */
`timescale 1ns / 1ps
// Channel  | Ports                          | Payload
// ---------+--------------------------------+------------------------------------------
// input    | in_valid, in_ready, in_data    | op, site_x, site_y, proposed_spin, rnd
// result   | out_valid, out_ready, out_data | accepted, site_spin
// config   | cfg_wr_en, cfg_wr_data         | beta_coupling, Q4.12
//
// Load and read items skip the neighbor sums. An update reads the site and its four
// neighbors through the one read port before the energy check. A change at or below zero
// ends without the series, as does one of 12 or more; else the 14-term exp series runs
// each term as a multiply, 5 divide chunks and an accumulate, then one multiply per
// integer unit of the change. A held result stalls the next item at its end.
// Reset (rst_n, synchronous) idles the block and sets beta to 1.0; lattice is kept.
module clock_model_metropolis_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cmmu_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cmmu_pkg::out_t                out_data,
  input  logic                          cfg_wr_en,
  input  logic [cmmu_pkg::BETA_W-1:0]   cfg_wr_data
);

  cmmu_pkg::cmd_t    cmd;
  cmmu_pkg::status_t status;

  cmmu_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  cmmu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

endmodule

/* hw/rtl/cmmu_checker.sv */
`timescale 1ns / 1ps
module cmmu_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input cmmu_pkg::out_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input item dropped before accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("new result while an item is in flight");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind clock_model_metropolis_update cmmu_checker u_cmmu_checker (.*);
